>>> design/wid_pkg.sv
// Package for the WebAssembly instruction decoder: word types, phase codes,
// class and error codes, opcode classing. No dependencies.
`default_nettype none
package wid_pkg;

  typedef struct packed {
    logic [7:0] byte_value;
    logic       last_byte;
  } in_word_t;

  typedef struct packed {
    logic [7:0]  opcode;
    logic [2:0]  instr_class;
    logic [2:0]  value_type;
    logic [63:0] immediate;
    logic [31:0] mem_offset;
    logic        is_default_target;
    logic        last_of_instr;
    logic [2:0]  error_code;
  } out_word_t;

  typedef enum logic [3:0] {
    PH_OPC, PH_BLOCKT, PH_IDX, PH_CI_IDX, PH_RESV_CI, PH_RESV_MEM, PH_ALIGN,
    PH_OFFSET, PH_BRT_COUNT, PH_BRT_TARGET, PH_BRT_DEFAULT, PH_S32, PH_S64,
    PH_RAW4, PH_RAW8
  } phase_t;

  localparam logic [2:0] CLS_CONTROL = 3'd0;
  localparam logic [2:0] CLS_PARAM   = 3'd1;
  localparam logic [2:0] CLS_VAR     = 3'd2;
  localparam logic [2:0] CLS_MEM     = 3'd3;
  localparam logic [2:0] CLS_NUM     = 3'd4;
  localparam logic [2:0] CLS_UNKNOWN = 3'd7;

  localparam logic [2:0] ERR_NONE     = 3'd0;
  localparam logic [2:0] ERR_UNKNOWN  = 3'd1;
  localparam logic [2:0] ERR_BLOCK    = 3'd2;
  localparam logic [2:0] ERR_RESERVED = 3'd3;
  localparam logic [2:0] ERR_TRUNC    = 3'd4;
  localparam logic [2:0] ERR_OVERLONG = 3'd5;

  localparam logic [2:0] VT_NONE = 3'd0;
  localparam logic [2:0] VT_I32  = 3'd1;
  localparam logic [2:0] VT_I64  = 3'd2;
  localparam logic [2:0] VT_F32  = 3'd3;
  localparam logic [2:0] VT_F64  = 3'd4;

  localparam logic [7:0] EMPTY_BLOCK   = 8'h40;
  localparam logic [7:0] RESERVED_ZERO = 8'h00;

  function automatic logic [2:0] class_of(input logic [7:0] op);
    if (op <= 8'h05 || (op >= 8'h0b && op <= 8'h11)) return CLS_CONTROL;
    if (op == 8'h1a || op == 8'h1b) return CLS_PARAM;
    if (op >= 8'h20 && op <= 8'h24) return CLS_VAR;
    if (op >= 8'h28 && op <= 8'h40) return CLS_MEM;
    if (op >= 8'h41 && op <= 8'hbf) return CLS_NUM;
    return CLS_UNKNOWN;
  endfunction

endpackage
`default_nettype wire

>>> design/wasm_instruction_decoder.sv
// WebAssembly MVP instruction decoder: top level with input and result
// registers. Depends on wid_pkg and wid_parser.
//
// Use: feed body bytes on the input channel (in_valid/in_stall, payload
// in_data with byte_value and last_byte); decoded records leave on the
// output channel (out_valid/out_stall, payload out_data).
// Each byte enters an input register, is parsed by one pass of logic and,
// when it completes an instruction, a br_table target or an error, its
// record lands in the result register.
// Throughput: one byte per cycle while the output does not stall, held
// by the single parser state update per byte.
// A stall on the output stops the parser on the byte at hand; the input
// register then holds that byte and stalls the input (an empty input
// register still takes one byte first).
// Reset clears both valid flags and puts the parser at expecting opcode.
`default_nettype none
module wasm_instruction_decoder (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wid_pkg::in_word_t      in_data,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output wid_pkg::out_word_t     out_data
);
  import wid_pkg::*;

  in_word_t  hold;
  logic      hold_valid;
  out_word_t rec;
  logic      rec_valid;
  logic      take;

  // advance the held byte when the result slot is free or leaving
  assign take     = hold_valid && (!out_valid || !out_stall);
  assign in_stall = hold_valid && !take;

  wid_parser u_parser (
    .clk(clk), .rst(rst), .take(take), .in_word(hold),
    .rec(rec), .rec_valid(rec_valid)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (!in_stall) begin
      hold_valid <= in_valid;
    end
    if (!in_stall && in_valid) hold <= in_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (take) begin
      out_valid <= rec_valid;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
    if (take && rec_valid) out_data <= rec;
  end

`ifndef SYNTH
  a_stall_needs_hold: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> hold_valid) else $error("stall without held byte");
  a_out_holds: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> (out_valid && $stable(out_data)))
    else $error("stalled record changed");
  a_err_last: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data.error_code != ERR_NONE) |-> out_data.last_of_instr)
    else $error("error record not last");
`endif
endmodule
`default_nettype wire

>>> design/wid_parser.sv
// Byte parser: phase, LEB accumulator and held fields; builds one record.
// Depends on wid_pkg.
`default_nettype none
module wid_parser (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               take,
  input  wid_pkg::in_word_t       in_word,
  output wid_pkg::out_word_t      rec,
  output logic                    rec_valid
);
  import wid_pkg::*;

  phase_t      phase, phase_next;
  logic [7:0]  held_opcode, held_opcode_next;
  logic [63:0] leb_acc, leb_acc_next;
  logic [3:0]  leb_cnt, leb_cnt_next;
  logic [31:0] targets_left, targets_left_next;
  logic [31:0] held_align, held_align_next;

  logic [7:0]  b;
  logic [2:0]  cls, bcls;
  logic [63:0] acc_or;
  logic [3:0]  n1;
  logic [6:0]  sh7;
  logic [2:0]  cnt3;
  logic        cont, is_s, over;
  logic [63:0] sval;
  logic [31:0] v32;

  always_comb begin
    b    = in_word.byte_value;
    cls  = class_of(held_opcode);
    bcls = class_of(b);
    sh7  = 7'(leb_cnt) * 7'd7;
    cnt3 = leb_cnt[2:0];
    n1   = leb_cnt + 4'd1;
    cont = b[7];
    is_s = (phase == PH_S32) || (phase == PH_S64);
    acc_or = leb_acc;
    if (leb_cnt < 4'd10) acc_or = leb_acc | ({57'd0, b[6:0]} << sh7[5:0]);
    over = cont && (n1 >= ((phase == PH_S64) ? 4'd10 : 4'd5));
    sval = acc_or;
    if (is_s && b[6] && (7'(n1) * 7'd7 < 7'd64))
      sval = acc_or | ({64{1'b1}} << 6'(7'(n1) * 7'd7));
    v32 = acc_or[31:0];

    phase_next = phase; held_opcode_next = held_opcode; leb_acc_next = leb_acc;
    leb_cnt_next = leb_cnt; targets_left_next = targets_left;
    held_align_next = held_align;
    rec_valid = 1'b0;
    rec = '0;
    rec.opcode = held_opcode;
    rec.instr_class = (cls == CLS_UNKNOWN) ? CLS_CONTROL : cls;
    rec.last_of_instr = 1'b1;

    case (phase)
      PH_OPC: begin
        held_opcode_next = b;
        rec.opcode = b;
        rec.instr_class = (bcls == CLS_UNKNOWN) ? CLS_CONTROL : bcls;
        leb_acc_next = '0; leb_cnt_next = '0;
        if (bcls == CLS_UNKNOWN) begin
          rec_valid = 1'b1; rec.error_code = ERR_UNKNOWN;
        end else if (b >= 8'h02 && b <= 8'h04) phase_next = PH_BLOCKT;
        else if (b == 8'h0c || b == 8'h0d || b == 8'h10 || bcls == CLS_VAR)
          phase_next = PH_IDX;
        else if (b == 8'h0e) phase_next = PH_BRT_COUNT;
        else if (b == 8'h11) phase_next = PH_CI_IDX;
        else if (b == 8'h3f || b == 8'h40) phase_next = PH_RESV_MEM;
        else if (bcls == CLS_MEM) phase_next = PH_ALIGN;
        else if (b == 8'h41) phase_next = PH_S32;
        else if (b == 8'h42) phase_next = PH_S64;
        else if (b == 8'h43) phase_next = PH_RAW4;
        else if (b == 8'h44) phase_next = PH_RAW8;
        else begin
          rec_valid = 1'b1; leb_acc_next = leb_acc; leb_cnt_next = leb_cnt;
        end
      end
      PH_BLOCKT: begin
        rec_valid = 1'b1; phase_next = PH_OPC;
        if (b == EMPTY_BLOCK) rec.value_type = VT_NONE;
        else if (b >= 8'h7c && b <= 8'h7f) rec.value_type = 3'(8'h80 - b);
        else rec.error_code = ERR_BLOCK;
      end
      PH_RESV_MEM, PH_RESV_CI: begin
        rec_valid = 1'b1; phase_next = PH_OPC;
        if (b != RESERVED_ZERO) rec.error_code = ERR_RESERVED;
        else if (phase == PH_RESV_CI) rec.immediate = {32'd0, held_align};
      end
      PH_S32, PH_S64: begin
        leb_acc_next = acc_or; leb_cnt_next = n1;
        if (over) begin
          rec_valid = 1'b1; rec.error_code = ERR_OVERLONG; phase_next = PH_OPC;
        end else if (!cont) begin
          rec_valid = 1'b1; phase_next = PH_OPC; leb_acc_next = sval;
          if (phase == PH_S32) begin
            rec.value_type = VT_I32;
            rec.immediate = {{32{sval[31]}}, sval[31:0]};
          end else begin
            rec.value_type = VT_I64; rec.immediate = sval;
          end
        end
      end
      PH_RAW4, PH_RAW8: begin
        leb_acc_next = leb_acc | ({56'd0, b} << {cnt3, 3'b000});
        leb_cnt_next = {1'b0, cnt3} + 4'd1;
        if (leb_cnt_next == ((phase == PH_RAW4) ? 4'd4 : 4'd8)) begin
          rec_valid = 1'b1; phase_next = PH_OPC;
          rec.value_type = (phase == PH_RAW4) ? VT_F32 : VT_F64;
          rec.immediate = leb_acc_next;
        end
      end
      default: begin
        leb_acc_next = acc_or; leb_cnt_next = n1;
        if (over) begin
          rec_valid = 1'b1; rec.error_code = ERR_OVERLONG; phase_next = PH_OPC;
        end else if (!cont) begin
          leb_acc_next = '0; leb_cnt_next = '0;
          case (phase)
            PH_IDX: begin
              rec_valid = 1'b1; rec.immediate = {32'd0, v32}; phase_next = PH_OPC;
              leb_acc_next = acc_or; leb_cnt_next = n1;
            end
            PH_CI_IDX: begin held_align_next = v32; phase_next = PH_RESV_CI; end
            PH_ALIGN: begin held_align_next = v32; phase_next = PH_OFFSET; end
            PH_OFFSET: begin
              rec_valid = 1'b1; rec.immediate = {32'd0, held_align};
              rec.mem_offset = v32; phase_next = PH_OPC;
              leb_acc_next = acc_or; leb_cnt_next = n1;
            end
            PH_BRT_COUNT: begin
              targets_left_next = v32;
              phase_next = (v32 != 32'd0) ? PH_BRT_TARGET : PH_BRT_DEFAULT;
            end
            PH_BRT_TARGET: begin
              rec_valid = 1'b1; rec.immediate = {32'd0, v32};
              rec.last_of_instr = 1'b0;
              targets_left_next = targets_left - 32'd1;
              phase_next = (targets_left_next != 32'd0) ? PH_BRT_TARGET
                                                         : PH_BRT_DEFAULT;
            end
            default: begin
              rec_valid = 1'b1; rec.immediate = {32'd0, v32};
              rec.is_default_target = 1'b1; phase_next = PH_OPC;
              leb_acc_next = acc_or; leb_cnt_next = n1;
            end
          endcase
        end
      end
    endcase

    // truncation overrides any record but another error or completion
    if (phase_next != PH_OPC && in_word.last_byte) begin
      phase_next = PH_OPC;
      rec_valid = 1'b1;
      rec.instr_class = (class_of(held_opcode_next) == CLS_UNKNOWN) ? CLS_CONTROL
                        : class_of(held_opcode_next);
      rec.opcode = held_opcode_next;
      rec.value_type = VT_NONE; rec.immediate = '0; rec.mem_offset = '0;
      rec.is_default_target = 1'b0; rec.last_of_instr = 1'b1;
      rec.error_code = ERR_TRUNC;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_OPC; held_opcode <= '0; leb_acc <= '0; leb_cnt <= '0;
      targets_left <= '0; held_align <= '0;
    end else if (take) begin
      phase <= phase_next; held_opcode <= held_opcode_next;
      leb_acc <= leb_acc_next; leb_cnt <= leb_cnt_next;
      targets_left <= targets_left_next; held_align <= held_align_next;
    end
  end
endmodule
`default_nettype wire
